// File: rtl/colour_key_span_extractor_core_macros.svh
// Assertion macros for the color key span extractor checker.
`ifndef COLOUR_KEY_SPAN_EXTRACTOR_CORE_MACROS_SVH
`define COLOUR_KEY_SPAN_EXTRACTOR_CORE_MACROS_SVH

// Condition checked at every edge outside reset.
`define CKSE_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CKSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ckse_pkg.sv
// Shared types and constants for the color key span extractor.
package ckse_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = 12;
  localparam int ROW_W      = 12;
  localparam int EDGE_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_MATCHING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LIMIT   = 2'd2;

  localparam logic [12:0] BATCH_LIMIT_RESET = 13'd2000;
  localparam logic [EDGE_W-1:0] BOX_EMPTY_LEFT = EDGE_W'(MAX_WIDTH);
  localparam logic [EDGE_W-1:0] BOX_EMPTY_TOP  = EDGE_W'(MAX_HEIGHT);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_HEIGHT - 1);

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        row_end;
    logic        frame_end;
  } ckse_in_t;

  typedef struct packed {
    logic              has_span;
    logic [11:0]       span_left;
    logic [12:0]       span_right;
    logic [11:0]       span_row;
    logic [EDGE_W-1:0] box_left;
    logic [EDGE_W-1:0] box_top;
    logic [EDGE_W-1:0] box_right;
    logic [EDGE_W-1:0] box_bottom;
    logic              batch_end;
  } ckse_out_t;

  // Row scan position and open run.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             in_run;
    logic [COL_W-1:0] run_start;
  } ckse_scan_t;

  // What the run detector reports for one pixel.
  typedef struct packed {
    logic              got;
    logic              frame_end;
    logic [COL_W-1:0]  span_left;
    logic [EDGE_W-1:0] span_right;
    logic [ROW_W-1:0]  span_row;
  } ckse_run_t;

endpackage

// File: rtl/ckse_run_detect.sv
// Key compare and run tracking for one pixel: span closure and next scan position.
module ckse_run_detect (
  input  ckse_pkg::ckse_in_t   pix,
  input  logic [23:0]          key_color,
  input  logic                 keep_matching,
  input  ckse_pkg::ckse_scan_t scan,
  output ckse_pkg::ckse_run_t  run,
  output ckse_pkg::ckse_scan_t scan_nxt
);

  logic match;
  logic region;
  logic row_end_eff;
  logic frame_end_eff;
  logic [ckse_pkg::COL_W-1:0] start;

  always_comb begin
    match         = (pix.pixel_rgb == key_color);
    region        = keep_matching ? match : !match;
    row_end_eff   = pix.row_end || pix.frame_end || (scan.col >= ckse_pkg::LAST_COL);
    frame_end_eff = pix.frame_end || (row_end_eff && (scan.row >= ckse_pkg::LAST_ROW));
    start         = (region && !scan.in_run) ? scan.col : scan.run_start;

    run.frame_end  = frame_end_eff;
    run.span_row   = scan.row;
    run.span_left  = start;
    run.got        = 1'b0;
    run.span_right = {1'b0, scan.col};
    if (region && row_end_eff) begin
      run.got        = 1'b1;
      run.span_right = {1'b0, scan.col} + 13'd1;
    end else if (!region && scan.in_run) begin
      run.got = 1'b1;
    end

    scan_nxt.run_start = start;
    if (frame_end_eff) begin
      scan_nxt.col       = '0;
      scan_nxt.row       = '0;
      scan_nxt.in_run    = 1'b0;
      scan_nxt.run_start = '0;
    end else if (row_end_eff) begin
      scan_nxt.col    = '0;
      scan_nxt.row    = scan.row + 12'd1;
      scan_nxt.in_run = 1'b0;
    end else begin
      scan_nxt.col    = scan.col + 12'd1;
      scan_nxt.row    = scan.row;
      scan_nxt.in_run = region;
    end
  end

endmodule

// File: rtl/colour_key_span_extractor_core.sv
// Top level of the color key span extractor: input register, span and batch logic, result register.
// One pixel request is accepted per clock while in_stall is low. A pixel waits in the input register
// and its result, if any, goes to the result register when the pixel stage fires; pixels that close
// no span keep moving while a result waits. The result register stalls the pixel stage only when that
// stage holds a pixel that closes a span or ends the frame. There is no clearing pass.
module colour_key_span_extractor_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ckse_pkg::ckse_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ckse_pkg::ckse_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ckse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ckse_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [23:0] key_color_r;
  logic        keep_matching_r;
  logic [12:0] batch_limit_r;

  logic                 pix_valid_r;
  ckse_pkg::ckse_in_t   pix_r;
  ckse_pkg::ckse_scan_t scan_r, scan_nxt;
  ckse_pkg::ckse_run_t  run;

  logic [12:0]                 spans_r, spans_nxt;
  logic [ckse_pkg::EDGE_W-1:0] bl_r, bt_r, br_r, bb_r;
  logic [ckse_pkg::EDGE_W-1:0] bl_nxt, bt_nxt, br_nxt, bb_nxt;
  logic [ckse_pkg::EDGE_W-1:0] ul, ut, ur, ub, row_edge, row_next;

  logic                out_valid_r;
  ckse_pkg::ckse_out_t out_r, res;
  logic produce, stage_fire, in_take, out_take, last;

  ckse_run_detect u_run (
    .pix           (pix_r),
    .key_color     (key_color_r),
    .keep_matching (keep_matching_r),
    .scan          (scan_r),
    .run           (run),
    .scan_nxt      (scan_nxt)
  );

  always_comb begin
    produce    = run.got || run.frame_end;
    out_take   = out_valid_r && !out_stall;
    stage_fire = pix_valid_r && !(produce && out_valid_r && out_stall);
    in_stall   = pix_valid_r && !stage_fire;
    in_take    = in_valid && !in_stall;

    row_edge = {1'b0, run.span_row};
    row_next = row_edge + 13'd1;
    ul = ({1'b0, run.span_left} < bl_r) ? {1'b0, run.span_left} : bl_r;
    ut = (row_edge < bt_r) ? row_edge : bt_r;
    ur = (run.span_right > br_r) ? run.span_right : br_r;
    ub = (row_next > bb_r) ? row_next : bb_r;
    spans_nxt = spans_r + 13'd1;
    last = (spans_nxt >= batch_limit_r) || run.frame_end;

    res.has_span   = run.got;
    res.span_left  = run.got ? run.span_left : '0;
    res.span_right = run.got ? run.span_right : '0;
    res.span_row   = run.got ? run.span_row : '0;
    res.box_left   = run.got ? ul : bl_r;
    res.box_top    = run.got ? ut : bt_r;
    res.box_right  = run.got ? ur : br_r;
    res.box_bottom = run.got ? ub : bb_r;
    res.batch_end  = run.got ? last : 1'b1;

    bl_nxt = bl_r;
    bt_nxt = bt_r;
    br_nxt = br_r;
    bb_nxt = bb_r;
    if (run.frame_end || (run.got && last)) begin
      spans_nxt = '0;
      bl_nxt    = ckse_pkg::BOX_EMPTY_LEFT;
      bt_nxt    = ckse_pkg::BOX_EMPTY_TOP;
      br_nxt    = '0;
      bb_nxt    = '0;
    end else if (run.got) begin
      bl_nxt = ul;
      bt_nxt = ut;
      br_nxt = ur;
      bb_nxt = ub;
    end else begin
      spans_nxt = spans_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_color_r     <= '0;
      keep_matching_r <= 1'b0;
      batch_limit_r   <= ckse_pkg::BATCH_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ckse_pkg::CFG_KEY_COLOR:     key_color_r     <= cfg_data;
        ckse_pkg::CFG_KEEP_MATCHING: keep_matching_r <= cfg_data[0];
        ckse_pkg::CFG_BATCH_LIMIT:   batch_limit_r   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      spans_r     <= '0;
      bl_r        <= ckse_pkg::BOX_EMPTY_LEFT;
      bt_r        <= ckse_pkg::BOX_EMPTY_TOP;
      br_r        <= '0;
      bb_r        <= '0;
    end else begin
      if (in_take) begin
        pix_valid_r <= 1'b1;
      end else if (stage_fire) begin
        pix_valid_r <= 1'b0;
      end
      if (stage_fire) begin
        scan_r  <= scan_nxt;
        spans_r <= spans_nxt;
        bl_r    <= bl_nxt;
        bt_r    <= bt_nxt;
        br_r    <= br_nxt;
        bb_r    <= bb_nxt;
      end
      if (stage_fire && produce) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pix_r <= in_data;
    end
    if (stage_fire && produce) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/ckse_port_checker.sv
// Port-level checker for the color key span extractor, bound to the top level.
`include "colour_key_span_extractor_core_macros.svh"

module ckse_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input ckse_pkg::ckse_out_t out_data
);

  logic out_held;
  logic marker_ok;
  logic span_ok;

  always_comb begin
    out_held  = out_valid && out_stall;
    marker_ok = !(out_valid && !out_data.has_span) || out_data.batch_end;
    span_ok   = !(out_valid && out_data.has_span) ||
                ((out_data.span_right > {1'b0, out_data.span_left}) &&
                 (out_data.box_left <= {1'b0, out_data.span_left}) &&
                 (out_data.box_right >= out_data.span_right));
  end

  `CKSE_ASSERT_NEXT(a_out_hold, out_held, out_valid, "stalled result dropped")
  `CKSE_ASSERT_NEXT(a_out_stable, out_held, $stable(out_data), "stalled result changed")
  `CKSE_ASSERT_HOLD(a_marker_ends_batch, marker_ok, "flush marker without batch end")
  `CKSE_ASSERT_HOLD(a_span_in_box, span_ok, "span outside its box")

endmodule

bind colour_key_span_extractor_core ckse_port_checker u_ckse_port_checker (.*);
